[hw/rtl/wss_pkg.sv]
// Shared types, widths and codes of the windowed sample statistics block.
package wss_pkg;

    localparam int TIME_W     = 48;
    localparam int VALUE_W    = 24;
    localparam int CNT_W      = 32;
    localparam int PTS_W      = 17;
    localparam int ACC_W      = 41;
    localparam int SQ_W       = 64;
    localparam int PT_SQ_W    = 47;
    localparam int PROD_W     = 82;
    localparam int DVD_W      = 81;
    localparam int DIVR_W     = 32;
    localparam int REM_W      = 33;
    localparam int SQRT_IN_W  = 46;
    localparam int SREM_W     = 25;
    localparam int ROOT_W     = 23;
    localparam int ITER_W     = 7;

    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 128;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [ITER_W-1:0] MUL_A_STEPS = ITER_W'(17);
    localparam logic [ITER_W-1:0] MUL_B_STEPS = ITER_W'(41);
    localparam logic [ITER_W-1:0] DIV_STEPS   = ITER_W'(81);
    localparam logic [ITER_W-1:0] SQRT_STEPS  = ITER_W'(23);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_SIZE = 2'd0,
        CFG_WINDOW_MODE = 2'd1,
        CFG_STATISTIC   = 2'd2
    } t_cfg_reg;

    typedef enum logic {
        MODE_TIME  = 1'b0,
        MODE_COUNT = 1'b1
    } t_win_mode;

    typedef enum logic [1:0] {
        STAT_AVG    = 2'd0,
        STAT_MIN    = 2'd1,
        STAT_MAX    = 2'd2,
        STAT_STDDEV = 2'd3
    } t_stat_sel;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CALC_INIT,
        OP_MUL_STEP,
        OP_MULB_INIT,
        OP_SUB,
        OP_DIV_STEP,
        OP_DIV_FIN,
        OP_SQRT_STEP,
        OP_SQRT_FIN,
        OP_MOD_INIT
    } t_calc_op;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_EVAL,
        ST_LATE,
        ST_CALC,
        ST_MULA,
        ST_MULB_INIT,
        ST_MULB,
        ST_SUB,
        ST_DIV,
        ST_DIV_FIN,
        ST_SQRT,
        ST_SQRT_FIN,
        ST_LOAD,
        ST_MOD,
        ST_MOD_DIV,
        ST_APPLY,
        ST_CLEAR
    } t_state;

    typedef struct packed {
        logic     capture;
        logic     eval;
        logic     apply;
        logic     clear_cnt;
        logic     load_stat;
        logic     load_late;
        t_calc_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic      mode_count;
        t_stat_sel stat;
        logic      late;
        logic      close_time;
        logic      has_samples;
        logic      realign;
        logic      cnt_close;
        logic      n_zero;
        logic      n_lt2;
        logic      sub_neg;
        logic      q_big;
        logic      iter_last;
        logic      out_free;
    } t_dp_status;

endpackage

[hw/rtl/wss_ctrl.sv]
// Controller state machine: sequences accumulation, window close and result hand-off.
module wss_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  wss_pkg::t_dp_status i_status,
    output wss_pkg::t_dp_cmd    o_cmd
);

    wss_pkg::t_state r_state;
    wss_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wss_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.op   = wss_pkg::OP_NONE;
        o_s_tready = 1'b0;
        unique case (r_state)
            wss_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = wss_pkg::ST_EVAL;
                end
            end
            wss_pkg::ST_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_status.mode_count) begin
                    n_state = wss_pkg::ST_APPLY;
                end else if (i_status.late) begin
                    n_state = wss_pkg::ST_LATE;
                end else if (i_status.close_time) begin
                    if (i_status.has_samples) begin
                        n_state = wss_pkg::ST_CALC;
                    end else if (i_status.realign) begin
                        n_state = wss_pkg::ST_MOD;
                    end else begin
                        n_state = wss_pkg::ST_APPLY;
                    end
                end else begin
                    n_state = wss_pkg::ST_APPLY;
                end
            end
            wss_pkg::ST_LATE: begin
                if (i_status.out_free) begin
                    o_cmd.load_late = 1'b1;
                    n_state         = wss_pkg::ST_APPLY;
                end
            end
            wss_pkg::ST_CALC: begin
                o_cmd.op = wss_pkg::OP_CALC_INIT;
                unique case (i_status.stat) inside
                    wss_pkg::STAT_MIN, wss_pkg::STAT_MAX: n_state = wss_pkg::ST_LOAD;
                    wss_pkg::STAT_AVG:
                        n_state = i_status.n_zero ? wss_pkg::ST_LOAD : wss_pkg::ST_DIV;
                    default:
                        n_state = i_status.n_lt2 ? wss_pkg::ST_LOAD : wss_pkg::ST_MULA;
                endcase
            end
            wss_pkg::ST_MULA: begin
                o_cmd.op = wss_pkg::OP_MUL_STEP;
                if (i_status.iter_last) begin
                    n_state = wss_pkg::ST_MULB_INIT;
                end
            end
            wss_pkg::ST_MULB_INIT: begin
                o_cmd.op = wss_pkg::OP_MULB_INIT;
                n_state  = wss_pkg::ST_MULB;
            end
            wss_pkg::ST_MULB: begin
                o_cmd.op = wss_pkg::OP_MUL_STEP;
                if (i_status.iter_last) begin
                    n_state = wss_pkg::ST_SUB;
                end
            end
            wss_pkg::ST_SUB: begin
                o_cmd.op = wss_pkg::OP_SUB;
                n_state  = i_status.sub_neg ? wss_pkg::ST_LOAD : wss_pkg::ST_DIV;
            end
            wss_pkg::ST_DIV: begin
                o_cmd.op = wss_pkg::OP_DIV_STEP;
                if (i_status.iter_last) begin
                    n_state = wss_pkg::ST_DIV_FIN;
                end
            end
            wss_pkg::ST_DIV_FIN: begin
                o_cmd.op = wss_pkg::OP_DIV_FIN;
                if (i_status.stat == wss_pkg::STAT_AVG || i_status.q_big) begin
                    n_state = wss_pkg::ST_LOAD;
                end else begin
                    n_state = wss_pkg::ST_SQRT;
                end
            end
            wss_pkg::ST_SQRT: begin
                o_cmd.op = wss_pkg::OP_SQRT_STEP;
                if (i_status.iter_last) begin
                    n_state = wss_pkg::ST_SQRT_FIN;
                end
            end
            wss_pkg::ST_SQRT_FIN: begin
                o_cmd.op = wss_pkg::OP_SQRT_FIN;
                n_state  = wss_pkg::ST_LOAD;
            end
            wss_pkg::ST_LOAD: begin
                if (i_status.out_free) begin
                    o_cmd.load_stat = 1'b1;
                    if (i_status.mode_count) begin
                        n_state = wss_pkg::ST_CLEAR;
                    end else if (i_status.realign) begin
                        n_state = wss_pkg::ST_MOD;
                    end else begin
                        n_state = wss_pkg::ST_APPLY;
                    end
                end
            end
            wss_pkg::ST_MOD: begin
                o_cmd.op = wss_pkg::OP_MOD_INIT;
                n_state  = wss_pkg::ST_MOD_DIV;
            end
            wss_pkg::ST_MOD_DIV: begin
                o_cmd.op = wss_pkg::OP_DIV_STEP;
                if (i_status.iter_last) begin
                    n_state = wss_pkg::ST_APPLY;
                end
            end
            wss_pkg::ST_APPLY: begin
                o_cmd.apply = 1'b1;
                if (i_status.mode_count && i_status.cnt_close) begin
                    n_state = wss_pkg::ST_CALC;
                end else begin
                    n_state = wss_pkg::ST_IDLE;
                end
            end
            wss_pkg::ST_CLEAR: begin
                o_cmd.clear_cnt = 1'b1;
                n_state         = wss_pkg::ST_IDLE;
            end
            default: begin
                n_state = wss_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/wss_datapath.sv]
// Datapath: configuration, window state, shared multiply/divide/sqrt unit, output register.
module wss_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  wss_pkg::t_dp_cmd                i_cmd,
    output wss_pkg::t_dp_status             o_status,
    input  logic [wss_pkg::S_TDATA_W-1:0]   i_s_tdata,
    input  logic                            i_s_tuser,
    input  logic                            i_s_tlast,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [wss_pkg::M_TDATA_W-1:0]   o_m_tdata,
    output logic                            o_m_tuser,
    input  logic                            i_cfg_we,
    input  logic [wss_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [wss_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam logic signed [wss_pkg::ACC_W-1:0] ACC_MAXPOS = 41'sd8388607;
    localparam logic signed [wss_pkg::ACC_W-1:0] ACC_MINNEG = -41'sd8388608;
    localparam logic [wss_pkg::VALUE_W-1:0]      VAL_MAXPOS = 24'h7FFFFF;

    function automatic logic signed [wss_pkg::ACC_W-1:0] acc_start(
        input wss_pkg::t_stat_sel s
    );
        logic signed [wss_pkg::ACC_W-1:0] v;
        case (s)
            wss_pkg::STAT_MIN: v = ACC_MAXPOS;
            wss_pkg::STAT_MAX: v = ACC_MINNEG;
            default:           v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [wss_pkg::TIME_W-1:0] end_of(
        input logic [wss_pkg::TIME_W-1:0] b,
        input logic [wss_pkg::CNT_W-1:0]  e
    );
        logic [wss_pkg::TIME_W:0] s;
        s = {1'b0, b} + {17'b0, e};
        return s[wss_pkg::TIME_W] ? '1 : s[wss_pkg::TIME_W-1:0];
    endfunction

    // captured item
    logic [wss_pkg::TIME_W-1:0]         r_in_time;
    logic signed [wss_pkg::VALUE_W-1:0] r_in_value;
    logic                               r_in_first;
    logic                               r_in_last;
    logic [wss_pkg::PT_SQ_W-1:0]        r_pt_sq;
    logic signed [2*wss_pkg::VALUE_W-1:0] pt_sq_full;

    // configuration
    logic [wss_pkg::CNT_W-1:0] r_win_len;
    wss_pkg::t_win_mode        r_win_mode;
    wss_pkg::t_stat_sel        r_stat_sel;
    logic [wss_pkg::CNT_W-1:0] cfg_size;
    wss_pkg::t_win_mode        cfg_mode;
    wss_pkg::t_stat_sel        cfg_stat;
    logic                      cfg_hit;
    logic [wss_pkg::CNT_W-1:0] cfg_eff;
    logic [wss_pkg::CNT_W-1:0] eff;

    // window state
    logic [wss_pkg::TIME_W-1:0]       r_begin, n_begin;
    logic [wss_pkg::TIME_W-1:0]       r_finish, n_finish;
    logic [wss_pkg::CNT_W-1:0]        r_samples, n_samples;
    logic [wss_pkg::PTS_W-1:0]        r_points, n_points;
    logic signed [wss_pkg::ACC_W-1:0] r_acc, n_acc;
    logic [wss_pkg::SQ_W-1:0]         r_sq, n_sq;
    logic                             r_dropping, n_dropping;

    logic signed [wss_pkg::ACC_W-1:0] v_ext;
    logic                             late, anchor, close_time, realign, add_en;
    logic [wss_pkg::TIME_W-1:0]       new_begin, end_t, end_nb;
    logic [wss_pkg::SQ_W:0]           sq_sum;
    logic [wss_pkg::CNT_W-1:0]        samp_after;

    // shared arithmetic unit
    logic [wss_pkg::ITER_W-1:0]    r_iter;
    logic [wss_pkg::PROD_W-1:0]    r_mc, r_prod, r_prod_a, prod_sum, sub_diff;
    logic [wss_pkg::ACC_W-1:0]     r_mb, acc_mag, avg_q, avg_neg;
    logic [wss_pkg::DVD_W-1:0]     r_dvd;
    logic [wss_pkg::DIVR_W-1:0]    r_div;
    logic [wss_pkg::REM_W-1:0]     r_rem;
    logic [wss_pkg::REM_W:0]       div_trial, div_diff;
    logic                          div_ge;
    logic [wss_pkg::SQRT_IN_W-1:0] r_sx;
    logic [wss_pkg::SREM_W-1:0]    r_srem;
    logic [wss_pkg::ROOT_W-1:0]    r_root;
    logic [wss_pkg::SREM_W+1:0]    sq_trial_rem, sq_diff;
    logic [wss_pkg::SREM_W-1:0]    sq_trial;
    logic                          sq_ge;
    logic [2*wss_pkg::PTS_W-1:0]   nn;
    logic [wss_pkg::VALUE_W-1:0]   r_stat;

    // output register
    logic                         r_out_valid;
    logic                         r_out_late;
    logic [wss_pkg::VALUE_W-1:0]  r_out_stat;
    logic [wss_pkg::TIME_W-1:0]   r_out_start;
    logic [wss_pkg::CNT_W-1:0]    r_out_samples;
    logic [wss_pkg::PTS_W-1:0]    r_out_points;

    // ---------------- configuration ----------------
    always_comb begin
        cfg_size = r_win_len;
        cfg_mode = r_win_mode;
        cfg_stat = r_stat_sel;
        cfg_hit  = 1'b0;
        if (i_cfg_we) begin
            unique case (wss_pkg::t_cfg_reg'(i_cfg_index))
                wss_pkg::CFG_WINDOW_SIZE: begin
                    cfg_size = i_cfg_data;
                    cfg_hit  = 1'b1;
                end
                wss_pkg::CFG_WINDOW_MODE: begin
                    cfg_mode = wss_pkg::t_win_mode'(i_cfg_data[0]);
                    cfg_hit  = 1'b1;
                end
                wss_pkg::CFG_STATISTIC: begin
                    cfg_stat = wss_pkg::t_stat_sel'(i_cfg_data[1:0]);
                    cfg_hit  = 1'b1;
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    assign cfg_eff = (cfg_size == '0) ? 32'd1 : cfg_size;
    assign eff     = (r_win_len == '0) ? 32'd1 : r_win_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len  <= 32'd1;
            r_win_mode <= wss_pkg::MODE_TIME;
            r_stat_sel <= wss_pkg::STAT_AVG;
        end else begin
            r_win_len  <= cfg_size;
            r_win_mode <= cfg_mode;
            r_stat_sel <= cfg_stat;
        end
    end

    // ---------------- item capture ----------------
    assign pt_sq_full = r_in_value * r_in_value;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_time  <= i_s_tdata[wss_pkg::TIME_W-1:0];
            r_in_value <= i_s_tdata[wss_pkg::S_TDATA_W-1:wss_pkg::TIME_W];
            r_in_first <= i_s_tuser;
            r_in_last  <= i_s_tlast;
        end
        if (i_cmd.eval) begin
            r_pt_sq <= pt_sq_full[wss_pkg::PT_SQ_W-1:0];
        end
    end

    // ---------------- window decisions ----------------
    assign v_ext      = wss_pkg::ACC_W'(r_in_value);
    assign late       = r_in_first && (r_in_time < r_begin);
    assign anchor     = r_in_first && !late && (r_begin == r_finish);
    assign close_time = r_in_first && !late && (r_begin != r_finish) && (r_in_time >= r_finish);
    assign realign    = {1'b0, r_in_time} >= ({1'b0, r_finish} + {17'b0, eff});
    assign new_begin  = realign ? (r_in_time - {16'b0, r_rem[wss_pkg::DIVR_W-1:0]}) : r_finish;
    assign end_t      = end_of(r_in_time, eff);
    assign end_nb     = end_of(new_begin, eff);
    assign samp_after = (r_in_first && r_samples != '1) ? r_samples + 1'b1 : r_samples;

    always_comb begin
        n_begin    = r_begin;
        n_finish   = r_finish;
        n_samples  = r_samples;
        n_points   = r_points;
        n_acc      = r_acc;
        n_sq       = r_sq;
        n_dropping = r_dropping;
        add_en     = 1'b0;
        sq_sum     = '0;
        if (cfg_hit) begin
            n_begin    = '0;
            n_finish   = (cfg_mode == wss_pkg::MODE_COUNT) ? {16'b0, cfg_eff} : '0;
            n_samples  = '0;
            n_points   = '0;
            n_acc      = acc_start(cfg_stat);
            n_sq       = '0;
            n_dropping = 1'b0;
        end else if (i_cmd.clear_cnt) begin
            n_begin   = '0;
            n_finish  = {16'b0, eff};
            n_samples = '0;
            n_points  = '0;
            n_acc     = acc_start(r_stat_sel);
            n_sq      = '0;
        end else if (i_cmd.apply) begin
            if (r_win_mode == wss_pkg::MODE_TIME) begin
                if (r_in_first) begin
                    n_dropping = 1'b0;
                    if (late) begin
                        n_dropping = 1'b1;
                    end else if (anchor) begin
                        n_begin  = r_in_time;
                        n_finish = end_t;
                    end else if (close_time) begin
                        n_begin   = new_begin;
                        n_finish  = end_nb;
                        n_samples = '0;
                        n_points  = '0;
                        n_acc     = acc_start(r_stat_sel);
                        n_sq      = '0;
                    end
                    if (!n_dropping && n_samples != '1) begin
                        n_samples = n_samples + 1'b1;
                    end
                end
                add_en = !n_dropping;
                if (r_in_last) begin
                    n_dropping = 1'b0;
                end
            end else begin
                n_dropping = 1'b0;
                if (r_in_first && n_samples != '1) begin
                    n_samples = n_samples + 1'b1;
                end
                add_en = 1'b1;
            end
            // drop points past the window's point capacity
            if (add_en && !n_points[wss_pkg::PTS_W-1]) begin
                n_points = n_points + 1'b1;
                case (r_stat_sel)
                    wss_pkg::STAT_MIN: begin
                        if (v_ext < n_acc) n_acc = v_ext;
                    end
                    wss_pkg::STAT_MAX: begin
                        if (v_ext > n_acc) n_acc = v_ext;
                    end
                    wss_pkg::STAT_AVG: begin
                        n_acc = n_acc + v_ext;
                    end
                    default: begin
                        n_acc  = n_acc + v_ext;
                        sq_sum = {1'b0, n_sq} + {18'b0, r_pt_sq};
                        n_sq   = sq_sum[wss_pkg::SQ_W] ? '1 : sq_sum[wss_pkg::SQ_W-1:0];
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_begin    <= '0;
            r_finish   <= '0;
            r_samples  <= '0;
            r_points   <= '0;
            r_acc      <= '0;
            r_sq       <= '0;
            r_dropping <= 1'b0;
        end else begin
            r_begin    <= n_begin;
            r_finish   <= n_finish;
            r_samples  <= n_samples;
            r_points   <= n_points;
            r_acc      <= n_acc;
            r_sq       <= n_sq;
            r_dropping <= n_dropping;
        end
    end

    // ---------------- shared arithmetic unit ----------------
    assign acc_mag      = r_acc[wss_pkg::ACC_W-1] ? (~r_acc + 1'b1) : r_acc;
    assign prod_sum     = r_prod + (r_mb[0] ? r_mc : '0);
    assign sub_diff     = r_prod_a - r_prod;
    assign nn           = r_points * (r_points - 1'b1);
    assign div_trial    = {r_rem, r_dvd[wss_pkg::DVD_W-1]};
    assign div_ge       = div_trial >= {2'b0, r_div};
    assign div_diff     = div_trial - {2'b0, r_div};
    assign sq_trial_rem = {r_srem, r_sx[wss_pkg::SQRT_IN_W-1 -: 2]};
    assign sq_trial     = {r_root, 2'b01};
    assign sq_ge        = sq_trial_rem >= {2'b0, sq_trial};
    assign sq_diff      = sq_trial_rem - {2'b0, sq_trial};
    assign avg_q        = r_dvd[wss_pkg::ACC_W-1:0];
    assign avg_neg      = ~avg_q + 1'b1;

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            wss_pkg::OP_CALC_INIT: begin
                if (r_stat_sel == wss_pkg::STAT_MIN || r_stat_sel == wss_pkg::STAT_MAX) begin
                    r_stat <= r_acc[wss_pkg::VALUE_W-1:0];
                end else begin
                    r_stat <= '0;
                end
                r_prod <= '0;
                r_mc   <= {18'b0, r_sq};
                r_mb   <= {24'b0, r_points};
                r_dvd  <= {40'b0, acc_mag};
                r_div  <= {15'b0, r_points};
                r_rem  <= '0;
                r_iter <= (r_stat_sel == wss_pkg::STAT_AVG) ? wss_pkg::DIV_STEPS
                                                             : wss_pkg::MUL_A_STEPS;
            end
            wss_pkg::OP_MUL_STEP: begin
                r_prod <= prod_sum;
                r_mc   <= r_mc << 1;
                r_mb   <= r_mb >> 1;
                r_iter <= r_iter - 1'b1;
            end
            wss_pkg::OP_MULB_INIT: begin
                r_prod_a <= r_prod;
                r_prod   <= '0;
                r_mc     <= {41'b0, acc_mag};
                r_mb     <= acc_mag;
                r_iter   <= wss_pkg::MUL_B_STEPS;
            end
            wss_pkg::OP_SUB: begin
                r_dvd  <= sub_diff[wss_pkg::DVD_W-1:0];
                r_div  <= nn[wss_pkg::DIVR_W-1:0];
                r_rem  <= '0;
                r_iter <= wss_pkg::DIV_STEPS;
            end
            wss_pkg::OP_DIV_STEP: begin
                r_rem  <= div_ge ? div_diff[wss_pkg::REM_W-1:0] : div_trial[wss_pkg::REM_W-1:0];
                r_dvd  <= {r_dvd[wss_pkg::DVD_W-2:0], div_ge};
                r_iter <= r_iter - 1'b1;
            end
            wss_pkg::OP_DIV_FIN: begin
                if (r_stat_sel == wss_pkg::STAT_AVG) begin
                    r_stat <= r_acc[wss_pkg::ACC_W-1] ? avg_neg[wss_pkg::VALUE_W-1:0]
                                                      : avg_q[wss_pkg::VALUE_W-1:0];
                end else if (o_status.q_big) begin
                    r_stat <= VAL_MAXPOS;
                end
                r_sx   <= r_dvd[wss_pkg::SQRT_IN_W-1:0];
                r_srem <= '0;
                r_root <= '0;
                r_iter <= wss_pkg::SQRT_STEPS;
            end
            wss_pkg::OP_SQRT_STEP: begin
                r_srem <= sq_ge ? sq_diff[wss_pkg::SREM_W-1:0] : sq_trial_rem[wss_pkg::SREM_W-1:0];
                r_root <= {r_root[wss_pkg::ROOT_W-2:0], sq_ge};
                r_sx   <= r_sx << 2;
                r_iter <= r_iter - 1'b1;
            end
            wss_pkg::OP_SQRT_FIN: begin
                r_stat <= {1'b0, r_root};
            end
            wss_pkg::OP_MOD_INIT: begin
                r_dvd  <= {33'b0, r_in_time};
                r_div  <= eff;
                r_rem  <= '0;
                r_iter <= wss_pkg::DIV_STEPS;
            end
            default: begin
            end
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_stat || i_cmd.load_late) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_late) begin
            r_out_late    <= 1'b1;
            r_out_stat    <= '0;
            r_out_start   <= '0;
            r_out_samples <= '0;
            r_out_points  <= '0;
        end else if (i_cmd.load_stat) begin
            r_out_late    <= 1'b0;
            r_out_stat    <= r_stat;
            r_out_start   <= (r_win_mode == wss_pkg::MODE_TIME) ? r_begin : '0;
            r_out_samples <= r_samples;
            r_out_points  <= r_points;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_late;
    assign o_m_tdata  = {7'b0, r_out_points, r_out_samples, r_out_start, r_out_stat};

    // ---------------- status ----------------
    assign o_status.mode_count  = (r_win_mode == wss_pkg::MODE_COUNT);
    assign o_status.stat        = r_stat_sel;
    assign o_status.late        = late;
    assign o_status.close_time  = close_time;
    assign o_status.has_samples = (r_samples != '0);
    assign o_status.realign     = realign;
    assign o_status.cnt_close   = r_in_last && ({16'b0, samp_after} >= r_finish);
    assign o_status.n_zero      = (r_points == '0);
    assign o_status.n_lt2       = (r_points < wss_pkg::PTS_W'(2));
    assign o_status.sub_neg     = (r_prod_a < r_prod);
    assign o_status.q_big       = |r_dvd[wss_pkg::DVD_W-1:wss_pkg::SQRT_IN_W];
    assign o_status.iter_last   = (r_iter == wss_pkg::ITER_W'(1));
    assign o_status.out_free    = !r_out_valid || i_m_tready;

endmodule

[hw/rtl/windowed_sample_statistics.sv]
// Top level of the windowed sample statistics block.
// Tumbling-window statistics (average, minimum, maximum or sample standard deviation) over
// Q16.8 points grouped into timestamped samples, in time or sample-count windows. One item is
// taken at a time: a point that closes no window passes the evaluate and apply states before
// the next ready; a late sample also waits in a late state for a free output register. A
// closing window adds the work of the shared one-bit-per-cycle arithmetic unit: 81 restoring
// divide steps for the average, none for minimum or maximum, and for the standard deviation
// 17 + 41 shift-add multiply steps, 81 divide steps and 23 square-root steps. A counter window
// also passes a clear state after the result is loaded. A time window that skips a whole
// window length re-aligns its start with another divider pass. A finished result waits in an
// output register, so the next item proceeds until a further result has to be loaded.
module windowed_sample_statistics (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [wss_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // timestamp[47:0], point_value[71:48]
    input  logic                             s_axis_tuser,  // first_in_sample
    input  logic                             s_axis_tlast,  // last_in_sample
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // statistic_value[23:0], window_start[71:24], samples_count[103:72], points_count[120:104]
    output logic [wss_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    output logic                             m_axis_tuser,  // status
    input  logic                             i_cfg_we,
    input  logic [wss_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [wss_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    wss_pkg::t_dp_cmd    cmd;
    wss_pkg::t_dp_status status;

    wss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    wss_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_s_tlast   (s_axis_tlast),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule
